// File: design/yb2r_pkg.sv
// ----------------------------------------------------------------------------
// yb2r_pkg: shared types and constants of the 4:2:0 block to RGB converter
// Coefficient widths, reset values, register map, clamp limits and the
// per-pixel clamp function.
// ----------------------------------------------------------------------------
package yb2r_pkg;

	// Field and register widths
	localparam int unsigned PIX_W      = 8;
	localparam int unsigned GAIN_W     = 17;
	localparam int unsigned RV_W       = 17;
	localparam int unsigned GU_W       = 16;
	localparam int unsigned GV_W       = 17;
	localparam int unsigned BU_W       = 17;
	localparam int unsigned OFF_W      = PIX_W + 1;
	localparam int unsigned SUM_W      = 29;
	localparam int unsigned LUMA_P_W   = PIX_W + GAIN_W;
	localparam int unsigned NUM_PIX    = 4;

	// Configuration port
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned ADDR_W     = 5;
	localparam int unsigned IDX_W      = 3;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_LUMA_GAIN    = 3'd0;
	localparam logic [IDX_W-1:0] REG_RED_FROM_V   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GREEN_FROM_U = 3'd2;
	localparam logic [IDX_W-1:0] REG_GREEN_FROM_V = 3'd3;
	localparam logic [IDX_W-1:0] REG_BLUE_FROM_U  = 3'd4;

	// Reset values
	localparam logic [GAIN_W-1:0] RST_LUMA_GAIN    = 17'd65536;
	localparam logic [RV_W-1:0]   RST_RED_FROM_V   = 17'd91881;
	localparam logic [GU_W-1:0]   RST_GREEN_FROM_U = 16'(-22553);
	localparam logic [GV_W-1:0]   RST_GREEN_FROM_V = 17'(-46801);
	localparam logic [BU_W-1:0]   RST_BLUE_FROM_U  = 17'd116129;

	localparam logic [PIX_W-1:0]  CHROMA_OFFSET    = 8'd128;
	localparam logic signed [SUM_W-1:0] HIGH_LIMIT = 29'sh0FFFFFF;
	localparam logic signed [SUM_W-1:0] LOW_LIMIT  = 29'sh000FFFF;

	typedef struct packed {
		logic [GAIN_W-1:0] luma_gain;
		logic [RV_W-1:0]   red_from_v;
		logic [GU_W-1:0]   green_from_u;
		logic [GV_W-1:0]   green_from_v;
		logic [BU_W-1:0]   blue_from_u;
	} cfg_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] red;
		logic signed [SUM_W-1:0] green;
		logic signed [SUM_W-1:0] blue;
	} chroma_terms_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_t;

	// Saturate a channel sum to one byte
	function automatic logic [PIX_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
		logic [PIX_W-1:0] res;
		if (sum > HIGH_LIMIT) begin
			res = '1;
		end else if (sum <= LOW_LIMIT) begin
			res = '0;
		end else begin
			res = sum[23:16];
		end
		return res;
	endfunction

endpackage

// File: design/yb2r_cfg_regs.sv
// ----------------------------------------------------------------------------
// yb2r_cfg_regs: coefficient register file
// APB-style write and read access to the gain and colour coefficients.
// ----------------------------------------------------------------------------
module yb2r_cfg_regs import yb2r_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Write the addressed register, drop writes beyond the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.luma_gain    <= RST_LUMA_GAIN;
			cfg_q.red_from_v   <= RST_RED_FROM_V;
			cfg_q.green_from_u <= RST_GREEN_FROM_U;
			cfg_q.green_from_v <= RST_GREEN_FROM_V;
			cfg_q.blue_from_u  <= RST_BLUE_FROM_U;
		end else if (wr_en) begin
			case (idx)
				REG_LUMA_GAIN:    cfg_q.luma_gain    <= pwdata[GAIN_W-1:0];
				REG_RED_FROM_V:   cfg_q.red_from_v   <= pwdata[RV_W-1:0];
				REG_GREEN_FROM_U: cfg_q.green_from_u <= pwdata[GU_W-1:0];
				REG_GREEN_FROM_V: cfg_q.green_from_v <= pwdata[GV_W-1:0];
				REG_BLUE_FROM_U:  cfg_q.blue_from_u  <= pwdata[BU_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back, signed coefficients sign extended
	always_comb begin
		case (idx)
			REG_LUMA_GAIN:    prdata = DATA_W'(cfg_q.luma_gain);
			REG_RED_FROM_V:   prdata = DATA_W'(cfg_q.red_from_v);
			REG_GREEN_FROM_U: prdata = DATA_W'($signed(cfg_q.green_from_u));
			REG_GREEN_FROM_V: prdata = DATA_W'($signed(cfg_q.green_from_v));
			REG_BLUE_FROM_U:  prdata = DATA_W'(cfg_q.blue_from_u);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: design/yb2r_chroma.sv
// ----------------------------------------------------------------------------
// yb2r_chroma: shared chroma terms of one block
// Removes the chroma offset and forms the red, green and blue chroma sums.
// ----------------------------------------------------------------------------
module yb2r_chroma import yb2r_pkg::*; (
	input  logic [PIX_W-1:0] chroma_u,
	input  logic [PIX_W-1:0] chroma_v,
	input  cfg_t             cfg,
	output chroma_terms_t    terms
);

	// Product widths: unsigned coefficients gain a zero sign bit
	localparam int unsigned RP_W  = RV_W + OFF_W + 1;
	localparam int unsigned GUP_W = GU_W + OFF_W;
	localparam int unsigned GVP_W = GV_W + OFF_W;
	localparam int unsigned BP_W  = BU_W + OFF_W + 1;

	logic signed [OFF_W-1:0] u_off;
	logic signed [OFF_W-1:0] v_off;
	logic signed [RP_W-1:0]  r_prod;
	logic signed [GUP_W-1:0] gu_prod;
	logic signed [GVP_W-1:0] gv_prod;
	logic signed [BP_W-1:0]  b_prod;

	// Centre the chroma bytes
	assign u_off = $signed({1'b0, chroma_u}) - $signed({1'b0, CHROMA_OFFSET});
	assign v_off = $signed({1'b0, chroma_v}) - $signed({1'b0, CHROMA_OFFSET});

	// Coefficient products
	assign r_prod  = RP_W'($signed({1'b0, cfg.red_from_v})) * RP_W'(v_off);
	assign gu_prod = GUP_W'($signed(cfg.green_from_u)) * GUP_W'(u_off);
	assign gv_prod = GVP_W'($signed(cfg.green_from_v)) * GVP_W'(v_off);
	assign b_prod  = BP_W'($signed({1'b0, cfg.blue_from_u})) * BP_W'(u_off);

	assign terms.red   = SUM_W'(r_prod);
	assign terms.green = SUM_W'(gu_prod) + SUM_W'(gv_prod);
	assign terms.blue  = SUM_W'(b_prod);

endmodule

// File: design/yb2r_pixel.sv
// ----------------------------------------------------------------------------
// yb2r_pixel: one output pixel
// Scales a luma byte by the gain, adds the chroma terms and clamps.
// ----------------------------------------------------------------------------
module yb2r_pixel import yb2r_pkg::*; (
	input  logic [PIX_W-1:0]  luma,
	input  logic [GAIN_W-1:0] luma_gain,
	input  chroma_terms_t     terms,
	output rgb_t              rgb
);

	logic [LUMA_P_W-1:0]     y_prod;
	logic signed [SUM_W-1:0] y_term;

	assign y_prod = LUMA_P_W'(luma) * LUMA_P_W'(luma_gain);
	assign y_term = $signed({{(SUM_W-LUMA_P_W){1'b0}}, y_prod});

	assign rgb.red   = clamp_channel(y_term + terms.red);
	assign rgb.green = clamp_channel(y_term + terms.green);
	assign rgb.blue  = clamp_channel(y_term + terms.blue);

endmodule

// File: design/yuv420_block_to_rgb_top.sv
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_top: 4:2:0 YCbCr 2x2 block to RGB converter
// Turns four luma bytes and one shared chroma pair into four RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one 2x2 block per request:
//   four luma bytes and the shared U and V bytes. Output channel
//   (out_valid / out_stall) returns one request of twelve clamped bytes,
//   red, green and blue for each of the four pixels.
//   A request is registered on entry, converted by one pass of multiply,
//   add and clamp logic and held in the result register (two register
//   stages, input and result). One block is accepted every cycle while
//   the output is not stalled. When the receiver stalls, the result
//   register holds its request and the input register fills; in_stall
//   rises once both are occupied. Reset empties both stages and loads
//   the coefficient registers with their BT.601 defaults (gain 1.0).
//   Coefficients are written over the APB port while no request is in
//   flight; pready is always high.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb_top import yb2r_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// Input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIX_W-1:0]  luma_top_left,
	input  logic [PIX_W-1:0]  luma_top_right,
	input  logic [PIX_W-1:0]  luma_bottom_left,
	input  logic [PIX_W-1:0]  luma_bottom_right,
	input  logic [PIX_W-1:0]  chroma_u,
	input  logic [PIX_W-1:0]  chroma_v,
	// Output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  red_top_left,
	output logic [PIX_W-1:0]  green_top_left,
	output logic [PIX_W-1:0]  blue_top_left,
	output logic [PIX_W-1:0]  red_top_right,
	output logic [PIX_W-1:0]  green_top_right,
	output logic [PIX_W-1:0]  blue_top_right,
	output logic [PIX_W-1:0]  red_bottom_left,
	output logic [PIX_W-1:0]  green_bottom_left,
	output logic [PIX_W-1:0]  blue_bottom_left,
	output logic [PIX_W-1:0]  red_bottom_right,
	output logic [PIX_W-1:0]  green_bottom_right,
	output logic [PIX_W-1:0]  blue_bottom_right
);

	cfg_t             cfg;
	chroma_terms_t    terms;
	logic             valid_s1;
	logic             valid_s2;
	logic             load_s1;
	logic             load_s2;
	logic [PIX_W-1:0] luma_s1 [NUM_PIX];
	logic [PIX_W-1:0] chroma_u_s1;
	logic [PIX_W-1:0] chroma_v_s1;
	rgb_t             rgb_comb [NUM_PIX];
	rgb_t             rgb_s2 [NUM_PIX];

	yb2r_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance control: result stage frees when empty or taken
	assign load_s2  = valid_s1 & (~valid_s2 | ~out_stall);
	assign load_s1  = in_valid & ~in_stall;
	assign in_stall = valid_s1 & ~load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (~out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (load_s1) begin
			luma_s1[0]  <= luma_top_left;
			luma_s1[1]  <= luma_top_right;
			luma_s1[2]  <= luma_bottom_left;
			luma_s1[3]  <= luma_bottom_right;
			chroma_u_s1 <= chroma_u;
			chroma_v_s1 <= chroma_v;
		end
	end

	yb2r_chroma u_chroma (
		.chroma_u (chroma_u_s1),
		.chroma_v (chroma_v_s1),
		.cfg      (cfg),
		.terms    (terms)
	);

	// One converter per pixel of the block
	for (genvar p = 0; p < NUM_PIX; p++) begin : g_pix
		yb2r_pixel u_pixel (
			.luma      (luma_s1[p]),
			.luma_gain (cfg.luma_gain),
			.terms     (terms),
			.rgb       (rgb_comb[p])
		);
	end

	// Result register, hold while stalled
	always_ff @(posedge clk) begin
		if (load_s2) begin
			rgb_s2 <= rgb_comb;
		end
	end

	assign out_valid          = valid_s2;
	assign red_top_left       = rgb_s2[0].red;
	assign green_top_left     = rgb_s2[0].green;
	assign blue_top_left      = rgb_s2[0].blue;
	assign red_top_right      = rgb_s2[1].red;
	assign green_top_right    = rgb_s2[1].green;
	assign blue_top_right     = rgb_s2[1].blue;
	assign red_bottom_left    = rgb_s2[2].red;
	assign green_bottom_left  = rgb_s2[2].green;
	assign blue_bottom_left   = rgb_s2[2].blue;
	assign red_bottom_right   = rgb_s2[3].red;
	assign green_bottom_right = rgb_s2[3].green;
	assign blue_bottom_right  = rgb_s2[3].blue;

endmodule
